/* design/mh2_pkg.sv */
// Shared constants, controller states and datapath command types for the MurmurHash2 block.
package mh2_pkg;

  localparam logic [31:0] MUL_CONST = 32'h5bd1e995;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX_K1,
    ST_MIX_K2,
    ST_MIX_H,
    ST_TAIL,
    ST_AVAL
  } mh2_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MIX_K1,
    OP_MIX_K2,
    OP_MIX_H,
    OP_TAIL,
    OP_AVAL
  } mh2_op_t;

  typedef struct packed {
    mh2_op_t op;
    logic    use_total;
  } mh2_cmd_t;

endpackage

/* design/mh2_dp.sv */
// Datapath: hash and chunk registers around one shared multiply by the mixing constant.
module mh2_dp (
  input  logic              clk,
  input  mh2_pkg::mh2_cmd_t cmd,
  input  logic [31:0]       word_data,
  input  logic [1:0]        byte_count,
  input  logic [31:0]       total_length,
  output logic [31:0]       hash_value
);

  logic [31:0] h_r;
  logic [31:0] k_r;
  logic [31:0] out_r;
  logic [1:0]  cnt_r;
  logic [31:0] keep;
  logic [31:0] mul_a;
  logic [31:0] prod;

  always_comb begin
    unique case (cnt_r)
      2'd1:    keep = 32'h0000_00ff;
      2'd2:    keep = 32'h0000_ffff;
      2'd3:    keep = 32'h00ff_ffff;
      default: keep = 32'h0000_0000;
    endcase
  end

  always_comb begin
    unique case (cmd.op)
      mh2_pkg::OP_MIX_K1: mul_a = k_r;
      mh2_pkg::OP_MIX_K2: mul_a = k_r ^ (k_r >> 24);
      mh2_pkg::OP_MIX_H:  mul_a = h_r;
      mh2_pkg::OP_TAIL:   mul_a = h_r ^ (k_r & keep);
      mh2_pkg::OP_AVAL:   mul_a = h_r ^ (h_r >> 13);
      default:            mul_a = 32'h0;
    endcase
  end

  assign prod = mul_a * mh2_pkg::MUL_CONST;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      mh2_pkg::OP_LOAD: begin
        k_r   <= word_data;
        cnt_r <= byte_count;
        if (cmd.use_total) begin
          h_r <= total_length;
        end
      end
      mh2_pkg::OP_MIX_K1: k_r   <= prod;
      mh2_pkg::OP_MIX_K2: k_r   <= prod;
      mh2_pkg::OP_MIX_H:  h_r   <= prod ^ k_r;
      mh2_pkg::OP_TAIL:   h_r   <= prod;
      mh2_pkg::OP_AVAL:   out_r <= prod;
      default: ;
    endcase
  end

  // last avalanche xor-shift sits after the output register
  assign hash_value = out_r ^ (out_r >> 15);

endmodule

/* design/mh2_ctrl.sv */
// Controller: sequences the mix steps per chunk and owns key and output handshake state.
module mh2_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2:0]        in_byte_count,
  input  logic              in_is_last,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output mh2_pkg::mh2_cmd_t cmd
);

  mh2_pkg::mh2_state_t state_r;
  mh2_pkg::mh2_state_t state_nxt;
  logic                last_r;
  logic                inside_r;
  logic                out_valid_r;
  logic                accept;
  logic                aval_fire;

  assign accept    = in_valid && (state_r == mh2_pkg::ST_IDLE);
  assign aval_fire = (state_r == mh2_pkg::ST_AVAL) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mh2_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_byte_count[2]) begin
            state_nxt = mh2_pkg::ST_MIX_K1;
          end else if (in_byte_count[1:0] != 2'd0) begin
            state_nxt = mh2_pkg::ST_TAIL;
          end else begin
            state_nxt = mh2_pkg::ST_AVAL;
          end
        end
      end
      mh2_pkg::ST_MIX_K1: state_nxt = mh2_pkg::ST_MIX_K2;
      mh2_pkg::ST_MIX_K2: state_nxt = mh2_pkg::ST_MIX_H;
      mh2_pkg::ST_MIX_H:  state_nxt = last_r ? mh2_pkg::ST_AVAL : mh2_pkg::ST_IDLE;
      mh2_pkg::ST_TAIL:   state_nxt = mh2_pkg::ST_AVAL;
      mh2_pkg::ST_AVAL: begin
        if (aval_fire) begin
          state_nxt = mh2_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mh2_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state_r != mh2_pkg::ST_IDLE);
    cmd.use_total = !inside_r;
    unique case (state_r)
      mh2_pkg::ST_IDLE:   cmd.op = in_valid ? mh2_pkg::OP_LOAD : mh2_pkg::OP_NONE;
      mh2_pkg::ST_MIX_K1: cmd.op = mh2_pkg::OP_MIX_K1;
      mh2_pkg::ST_MIX_K2: cmd.op = mh2_pkg::OP_MIX_K2;
      mh2_pkg::ST_MIX_H:  cmd.op = mh2_pkg::OP_MIX_H;
      mh2_pkg::ST_TAIL:   cmd.op = mh2_pkg::OP_TAIL;
      mh2_pkg::ST_AVAL:   cmd.op = aval_fire ? mh2_pkg::OP_AVAL : mh2_pkg::OP_NONE;
      default:            cmd.op = mh2_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mh2_pkg::ST_IDLE;
      last_r      <= 1'b0;
      inside_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        last_r <= in_is_last;
      end
      if ((state_r == mh2_pkg::ST_MIX_H) && !last_r) begin
        inside_r <= 1'b1;
      end else if (aval_fire) begin
        inside_r <= 1'b0;
      end
      if (aval_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* design/murmur2_hash32.sv */
// MurmurHash2 (32-bit, seed zero) over a stream of little-endian 32-bit key chunks.
// One chunk at a time through a single shared 32x32 multiply by the mixing constant.
// After accept: full chunk key mix twice, hash mix, avalanche if last; short chunk
// tail mix, avalanche; empty chunk avalanche; hash registered, offered next cycle.
// The final step waits while a previous hash is still stalled in the output register.
// Synchronous active-low reset clears the controller, key and output valid state.
module murmur2_hash32 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_word_data,
  input  logic [2:0]  in_byte_count,
  input  logic        in_is_last,
  input  logic [31:0] in_total_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);

  mh2_pkg::mh2_cmd_t cmd;

  mh2_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_byte_count(in_byte_count),
    .in_is_last   (in_is_last),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd)
  );

  mh2_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .word_data   (in_word_data),
    .byte_count  (in_byte_count[1:0]),
    .total_length(in_total_length),
    .hash_value  (out_hash_value)
  );

endmodule

/* dv/murmur2_checker.sv */
// Beat monitor, MurmurHash2 predictor and hash comparison for murmur2_hash32.
module murmur2_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_word_data,
  input  logic [2:0]  in_byte_count,
  input  logic        in_is_last,
  input  logic [31:0] in_total_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_hash_value,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] MIX_MUL = 32'h5bd1e995;

  logic [31:0] hash_acc;
  logic        key_open;
  logic [31:0] hash_q[$];
  int          errors = 0;

  function automatic logic [31:0] scramble_word(input logic [31:0] k);
    logic [31:0] x;
    x = k * MIX_MUL;
    x = x ^ (x >> 24);
    x = x * MIX_MUL;
    return x;
  endfunction

  function automatic logic [31:0] avalanche32(input logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h >> 13);
    x = x * MIX_MUL;
    x = x ^ (x >> 15);
    return x;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  task automatic absorb_chunk(input logic [31:0] word, input logic [2:0] count,
                              input logic last, input logic [31:0] total);
    logic [31:0] h;
    logic [31:0] keep;
    h = key_open ? hash_acc : total;
    if (count >= 3'd4) begin
      h = (h * MIX_MUL) ^ scramble_word(word);
      if (!last) begin
        hash_acc = h;
        key_open = 1'b1;
        return;
      end
    end else if (count != 3'd0) begin
      keep = (count == 3'd1) ? 32'h0000_00ff :
             (count == 3'd2) ? 32'h0000_ffff : 32'h00ff_ffff;
      h = h ^ (word & keep);
      h = h * MIX_MUL;
    end
    h = avalanche32(h);
    hash_acc = h;
    key_open = 1'b0;
    hash_q.push_back(h);
  endtask

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      hash_acc = '0;
      key_open = 1'b0;
      hash_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (hash_q.size() == 0) begin
          report($sformatf("hash beat %08h with nothing expected", out_hash_value));
        end else begin
          want = hash_q.pop_front();
          if (out_hash_value !== want)
            report($sformatf("hash_value %08h, expected %08h", out_hash_value, want));
        end
      end
      if (in_valid && !in_stall)
        absorb_chunk(in_word_data, in_byte_count, in_is_last, in_total_length);
    end
    fail_count <= errors;
    pending_count <= hash_q.size();
  end

endmodule

/* dv/testbench.sv */
// Top-level bench for murmur2_hash32: clock, reset, chunk stimulus, stall control and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_BEATS = 1550;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_word_data = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_is_last = 1'b0;
  logic [31:0] in_total_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_hash_value;

  int fail_count;
  int pending_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  bit hold_req = 1'b0;

  always #4 clk = ~clk;

  murmur2_hash32 uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word_data   (in_word_data),
    .in_byte_count  (in_byte_count),
    .in_is_last     (in_is_last),
    .in_total_length(in_total_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

  murmur2_checker hash_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word_data   (in_word_data),
    .in_byte_count  (in_byte_count),
    .in_is_last     (in_is_last),
    .in_total_length(in_total_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  // receiver: random stalls, or one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_beat(input logic [31:0] word, input logic [2:0] count,
                           input logic last, input logic [31:0] total);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_word_data    <= word;
    in_byte_count   <= count;
    in_is_last      <= last;
    in_total_length <= total;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic send_key();
    int          len;
    int          n_full;
    int          rem;
    bit          end_on_full;
    logic [31:0] total;
    logic [2:0]  count;
    len = ($urandom_range(99) < 70) ? $urandom_range(16) :
          ($urandom_range(99) < 90) ? $urandom_range(64, 17) : $urandom_range(200, 65);
    total = ($urandom_range(99) < 8) ? $urandom() : len;
    n_full = len / 4;
    rem = len % 4;
    end_on_full = (n_full > 0 && rem == 0 && $urandom_range(1) == 1);
    for (int i = 0; i < n_full; i++) begin
      count = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'd4;
      send_beat($urandom(), count, end_on_full && i == n_full - 1,
                (i == 0) ? total : $urandom());
    end
    if (!end_on_full)
      send_beat($urandom(), 3'(rem), $urandom_range(4) != 0,
                (n_full == 0) ? total : $urandom());
  endtask

  initial begin
    int guard;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty key, short tails, full chunks, oversized counts, ignored bytes
    send_beat(32'h0000_0000, 3'd0, 1'b1, 32'd0);
    send_beat(32'hffff_ffff, 3'd0, 1'b0, 32'hffff_ffff);
    send_beat(32'hffff_ffff, 3'd1, 1'b1, 32'd1);
    send_beat(32'hffff_ffff, 3'd2, 1'b1, 32'd2);
    send_beat(32'hffff_ffff, 3'd3, 1'b0, 32'd3);
    send_beat(32'hffff_ffff, 3'd4, 1'b1, 32'd4);
    send_beat(32'h0000_0000, 3'd4, 1'b1, 32'hffff_ffff);
    send_beat(32'h0302_0100, 3'd4, 1'b0, 32'd8);
    send_beat(32'h0706_0504, 3'd4, 1'b0, 32'hdead_beef);
    send_beat(32'hffff_ffff, 3'd0, 1'b1, 32'hffff_ffff);
    send_beat(32'h6463_6261, 3'd5, 1'b0, 32'd7);
    send_beat(32'hff67_6665, 3'd3, 1'b1, 32'd0);
    send_beat(32'h1234_5678, 3'd6, 1'b1, 32'd4);
    send_beat(32'h9abc_def0, 3'd7, 1'b0, 32'd12);
    send_beat(32'ha5a5_a5a5, 3'd2, 1'b0, 32'hffff_ffff);
    send_beat(32'h5a5a_5a5a, 3'd4, 1'b0, 32'd100);
    send_beat(32'h0f0f_0f0f, 3'd1, 1'b0, 32'h8000_0000);

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      if (p == 0) hold_req = 1'b1;
      while (beats_sent < 17 + (p + 1) * KEY_BEATS / 8) begin
        if ($urandom_range(9) == 0)
          send_beat($urandom(), 3'($urandom_range(7)), 1'($urandom_range(1)), $urandom());
        else
          send_key();
      end
      if (p == 3) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
      end
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending_count != 0 && guard < 20000);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
